// ===== rtl/core/b64u_pkg.sv =====
// Shared types for the base64url encoder.
// No dependencies; imported by the front, queue and back modules.
`default_nettype none
package b64u_pkg;

    // One classified byte: first 6-bit group, optional second group.
    typedef struct packed {
        logic [5:0] six0;
        logic [5:0] six1;
        logic       two;
    } t_job;

    // Queue status seen by the two sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

// ===== rtl/core/b64u_front.sv =====
// Front end: holds the bit residue and splits each byte into 6-bit groups.
// Depends on b64u_pkg.
`default_nettype none
module b64u_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic         i_last_byte,
    output b64u_pkg::t_job    o_job
);
    import b64u_pkg::*;

    typedef enum logic [2:0] {
        PH_NONE = 3'b001,
        PH_TWO  = 3'b010,
        PH_FOUR = 3'b100
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [3:0] r_bits, n_bits;

    always_comb begin
        o_job   = '0;
        n_phase = PH_NONE;
        n_bits  = 4'd0;
        case (r_phase)
            PH_TWO: begin
                o_job.six0 = {r_bits[1:0], i_data_byte[7:4]};
                o_job.six1 = {i_data_byte[3:0], 2'b00};
                o_job.two  = i_last_byte;
                n_phase    = PH_FOUR;
                n_bits     = i_data_byte[3:0];
            end
            PH_FOUR: begin
                o_job.six0 = {r_bits[3:0], i_data_byte[7:6]};
                o_job.six1 = i_data_byte[5:0];
                o_job.two  = 1'b1;
            end
            default: begin
                o_job.six0 = i_data_byte[7:2];
                o_job.six1 = {i_data_byte[1:0], 4'b0000};
                o_job.two  = i_last_byte;
                n_phase    = PH_TWO;
                n_bits     = {2'b00, i_data_byte[1:0]};
            end
        endcase
        // drop the residue at the end of a message
        if (i_last_byte) begin
            n_phase = PH_NONE;
            n_bits  = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NONE;
            r_bits  <= 4'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_bits  <= n_bits;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/b64u_queue.sv =====
// Short job queue between the front and back ends.
// Depends on b64u_pkg.
`default_nettype none
module b64u_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire b64u_pkg::t_job i_job,
    input  wire logic          i_pop,
    output b64u_pkg::t_job     o_job,
    output b64u_pkg::t_q_stat  o_stat
);
    import b64u_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push, w_do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_do_push    = i_push && !o_stat.full;
    assign w_do_pop     = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/b64u_back.sv =====
// Back end: turns queued jobs into one ASCII symbol per cycle while i_pop is high.
// Depends on b64u_pkg.
`default_nettype none
module b64u_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire b64u_pkg::t_job    i_job,
    input  wire b64u_pkg::t_q_stat i_stat,
    output logic                   o_q_pop,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output logic [6:0]             o_symbol,
    output logic                   o_end_of_output
);
    import b64u_pkg::*;

    localparam logic [6:0] CH_UPPER_A = 7'h41;
    localparam logic [6:0] CH_LOWER_A = 7'h61;
    localparam logic [6:0] CH_DIGIT_0 = 7'h30;
    localparam logic [6:0] CH_DASH    = 7'h2D;
    localparam logic [6:0] CH_USCORE  = 7'h5F;

    function automatic logic [6:0] to_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26) begin
            c = CH_UPPER_A + {1'b0, v};
        end else if (v < 6'd52) begin
            c = CH_LOWER_A + {1'b0, v - 6'd26};
        end else if (v < 6'd62) begin
            c = CH_DIGIT_0 + {1'b0, v - 6'd52};
        end else if (v == 6'd62) begin
            c = CH_DASH;
        end else begin
            c = CH_USCORE;
        end
        return c;
    endfunction

    logic       r_out_valid, r_pend;
    logic [5:0] r_pend_six;
    logic       w_load;

    assign w_load   = !r_out_valid || i_pop;
    assign o_q_pop  = w_load && !r_pend && !i_stat.empty;
    assign o_empty  = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else if (w_load) begin
            if (r_pend) begin
                r_out_valid <= 1'b1;
                r_pend      <= 1'b0;
            end else if (!i_stat.empty) begin
                r_out_valid <= 1'b1;
                r_pend      <= i_job.two;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_pend) begin
                o_symbol        <= to_char(r_pend_six);
                o_end_of_output <= 1'b1;
            end else begin
                o_symbol        <= to_char(i_job.six0);
                o_end_of_output <= !i_job.two;
                r_pend_six      <= i_job.six1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/base64url_encoder.sv =====
// Top level of the streaming unpadded base64url encoder.
// Depends on b64u_pkg, b64u_front, b64u_queue and b64u_back.
//
// Usage:
//   Input channel is a queue write port: a word (data byte plus last-byte
//   flag) is taken at a rising edge with push high and full low.
//   Result channel is a queue read port: while empty is low the oldest
//   symbol sits on o_symbol / o_end_of_output; it is taken at an edge with
//   pop high. end_of_output marks the final symbol caused by one byte.
// Path: a taken byte is written into the job queue, then its first symbol is loaded into the output register.
// Throughput: the output register moves one symbol per cycle while pop is
//   high; a byte yields one symbol, or two (every third byte, or a flushing
//   last byte), and new bytes are taken while the job queue has room.
// Stall: when pop stays low the output register holds its symbol, the job
//   queue fills (QUEUE_DEPTH words) and full rises until pop resumes.
// Reset: synchronous, active low; clears the residue, the queue and the
//   output register, so the next byte starts a fresh message.
`default_nettype none
module base64url_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic        pop,
    output logic             empty,
    output logic [6:0]       o_symbol,
    output logic             o_end_of_output
);
    import b64u_pkg::*;

    t_job    w_front_job, w_q_job;
    t_q_stat w_q_stat;
    logic    w_accept, w_q_pop;

    // take a byte whenever the job queue has room
    assign full     = w_q_stat.full;
    assign w_accept = push && !w_q_stat.full;

    b64u_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_job       (w_front_job)
    );

    // decouple classification from symbol output
    b64u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_job   (w_front_job),
        .i_pop   (w_q_pop),
        .o_job   (w_q_job),
        .o_stat  (w_q_stat)
    );

    // emit one symbol per cycle while pop is high, second group of a job held aside
    b64u_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (w_q_job),
        .i_stat          (w_q_stat),
        .o_q_pop         (w_q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_symbol        (o_symbol),
        .o_end_of_output (o_end_of_output)
    );

endmodule
`default_nettype wire

// ===== rtl/core/b64u_checker.sv =====
// Port-level checks for the base64url encoder, bound to its top level.
// Depends on base64url_encoder.
`default_nettype none
module b64u_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic       pop,
    input wire logic       empty,
    input wire logic [6:0] o_symbol,
    input wire logic       o_end_of_output
);

    // reset leaves nothing to read
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result present after reset");

    // a stalled symbol holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_symbol) && $stable(o_end_of_output)))
        else $error("stalled symbol changed");

    // only URL-safe alphabet characters come out
    a_alphabet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_symbol >= 7'h41 && o_symbol <= 7'h5A) ||
                    (o_symbol >= 7'h61 && o_symbol <= 7'h7A) ||
                    (o_symbol >= 7'h30 && o_symbol <= 7'h39) ||
                    o_symbol == 7'h2D || o_symbol == 7'h5F))
        else $error("symbol outside alphabet");

    // full rises only after a byte was taken
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("full rose without a write");

endmodule

bind base64url_encoder b64u_checker u_b64u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .push            (push),
    .full            (full),
    .pop             (pop),
    .empty           (empty),
    .o_symbol        (o_symbol),
    .o_end_of_output (o_end_of_output)
);
`default_nettype wire

// ===== dv/b64u_encode_check.sv =====
// Symbol checker for the base64url encoder: predicts and compares.
// Watches the byte and symbol channels of base64url_encoder; no dependencies.
`timescale 1ns / 100ps
module b64u_encode_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_pop,
    input  logic       i_empty,
    input  logic [6:0] i_symbol,
    input  logic       i_end_of_output,
    output int         o_mismatches,
    output int         o_outstanding
);

    localparam logic [6:0] ASCII_UPPER_A = 7'h41;
    localparam logic [6:0] ASCII_LOWER_A = 7'h61;
    localparam logic [6:0] ASCII_ZERO    = 7'h30;
    localparam logic [6:0] ASCII_DASH    = 7'h2D;
    localparam logic [6:0] ASCII_USCORE  = 7'h5F;
    localparam int         REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [6:0] symbol;
        logic       end_of_byte;
    } t_sym_word;

    t_sym_word  expected_symbols[$];
    logic [3:0] left_bits;
    int         left_count;

    function automatic logic [6:0] base64url_char(input logic [5:0] six);
        if (six < 6'd26) begin
            return ASCII_UPPER_A + 7'(six);
        end else if (six < 6'd52) begin
            return ASCII_LOWER_A + 7'(six - 6'd26);
        end else if (six < 6'd62) begin
            return ASCII_ZERO + 7'(six - 6'd52);
        end else if (six == 6'd62) begin
            return ASCII_DASH;
        end
        return ASCII_USCORE;
    endfunction

    // Split one byte plus the leftover bits into 6-bit groups; flush on last.
    task automatic encode_byte(input logic [7:0] b, input logic is_last);
        logic [11:0] acc;
        logic [5:0]  groups[2];
        int          nbits;
        int          n;
        t_sym_word   word;
        n     = 0;
        acc   = {left_bits, b};
        nbits = left_count + 8;
        while (nbits >= 6) begin
            groups[n] = 6'(acc >> (nbits - 6));
            n++;
            nbits -= 6;
        end
        acc = acc & ((12'd1 << nbits) - 12'd1);
        if (is_last && nbits > 0) begin
            groups[n] = 6'(acc << (6 - nbits));
            n++;
            nbits = 0;
            acc   = '0;
        end
        for (int k = 0; k < n; k++) begin
            word.symbol      = base64url_char(groups[k]);
            word.end_of_byte = (k == n - 1);
            expected_symbols.insert(expected_symbols.size(), word);
        end
        if (is_last) begin
            left_bits  = '0;
            left_count = 0;
        end else begin
            left_bits  = acc[3:0];
            left_count = nbits;
        end
    endtask

    always @(posedge i_clk) begin
        t_sym_word want;
        if (!i_rst_n) begin
            expected_symbols.delete();
            left_bits     = '0;
            left_count    = 0;
            o_mismatches  <= 0;
            o_outstanding <= 0;
        end else begin
            // Compare the popped word first: it can never stem from this edge's byte.
            if (i_pop && !i_empty) begin
                if (expected_symbols.size() == 0) begin
                    o_mismatches <= o_mismatches + 1;
                    if (o_mismatches < REPORT_LIMIT)
                        $display("%0t: unexpected word symbol=%h end=%b",
                                 $realtime, i_symbol, i_end_of_output);
                end else begin
                    want = expected_symbols.pop_front();
                    if (i_symbol !== want.symbol || i_end_of_output !== want.end_of_byte) begin
                        o_mismatches <= o_mismatches + 1;
                        if (o_mismatches < REPORT_LIMIT)
                            $display("%0t: symbol exp %h got %h, end exp %b got %b",
                                     $realtime, want.symbol, i_symbol,
                                     want.end_of_byte, i_end_of_output);
                    end
                end
            end
            if (i_push && !i_full)
                encode_byte(i_data_byte, i_last_byte);
            o_outstanding <= expected_symbols.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// Top of the base64url encoder testbench: clock, reset, stimulus and verdict.
// Depends on base64url_encoder (rtl) and b64u_encode_check (dv).
`timescale 1ns / 100ps
module tb;

    localparam int TARGET_BYTES = 1200;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 20;

    // Receiver behavior, held for a random stretch of cycles at a time.
    typedef enum logic [1:0] {
        DRAIN_FREE,
        DRAIN_COIN,
        DRAIN_SPARSE,
        DRAIN_LONG_HOLD
    } t_drain_mode;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_data_byte;
    logic       i_last_byte;
    logic       pop;
    logic       empty;
    logic [6:0] o_symbol;
    logic       o_end_of_output;

    int mismatches;
    int outstanding;
    int cycles = 0;
    int burst_left;
    int bytes_sent;

    base64url_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .pop             (pop),
        .empty           (empty),
        .o_symbol        (o_symbol),
        .o_end_of_output (o_end_of_output)
    );

    b64u_encode_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .i_pop           (pop),
        .i_empty         (empty),
        .i_symbol        (o_symbol),
        .i_end_of_output (o_end_of_output),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the block hangs or loses words.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one word and hold it until taken. Call and return at a falling edge;
    // full is read right after the rising edge, so it is the value the edge saw.
    task automatic send_word(input logic [7:0] b, input logic is_last);
        push        <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= is_last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Send a word inside the current burst; when the burst runs out, draw the
    // next burst length, then drop push for a random gap.
    task automatic offer_byte(input logic [7:0] b, input logic is_last);
        int gap;
        send_word(b, is_last);
        bytes_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            // Mostly short bursts, now and then a long stretch with no gaps.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Stimulus: directed messages first, then random messages.
    initial begin
        int msg_len;
        push        = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        i_rst_n     = 1'b0;
        bytes_sent  = 0;
        burst_left  = $urandom_range(1, 16);
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // One-byte messages: all zeros and all ones, flushing two leftover bits.
        offer_byte(8'h00, 1'b1);
        offer_byte(8'hFF, 1'b1);
        // Three bytes giving only dash symbols, then only underscores:
        // last byte lands with no leftover, so nothing is added.
        offer_byte(8'hFB, 1'b0);
        offer_byte(8'hEF, 1'b0);
        offer_byte(8'hBE, 1'b1);
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'hFF, 1'b1);
        // Two-byte messages: flush four leftover bits.
        offer_byte(8'h00, 1'b0);
        offer_byte(8'h00, 1'b1);
        offer_byte(8'h12, 1'b0);
        offer_byte(8'h34, 1'b1);
        // Plain text, then a run hitting the digit range of the alphabet.
        offer_byte(8'h4D, 1'b0);
        offer_byte(8'h61, 1'b0);
        offer_byte(8'h6E, 1'b1);
        offer_byte(8'hD3, 1'b0);
        offer_byte(8'h5D, 1'b0);
        offer_byte(8'hB7, 1'b1);
        // Four bytes: wraps around the three-byte cycle before the flush.
        offer_byte(8'h01, 1'b0);
        offer_byte(8'h02, 1'b0);
        offer_byte(8'h03, 1'b0);
        offer_byte(8'h04, 1'b1);

        // Random messages, mostly short, some long enough to cycle many times.
        while (bytes_sent < TARGET_BYTES) begin
            msg_len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
            for (int k = 1; k <= msg_len; k++)
                offer_byte(8'($urandom), k == msg_len);
        end
        push <= 1'b0;

        // Drain everything still expected, then watch a while for stray words.
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Receiver: change the stall pattern every stretch of cycles so that
    // stalls land on every phase, with free-running stretches in between.
    initial begin
        t_drain_mode mode;
        int          span;
        int          hold;
        pop  = 1'b0;
        hold = 0;
        forever begin
            mode = t_drain_mode'($urandom_range(0, 3));
            span = $urandom_range(32, 256);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    DRAIN_FREE: begin
                        pop <= 1'b1;
                    end
                    DRAIN_COIN: begin
                        pop <= 1'($urandom_range(0, 1));
                    end
                    DRAIN_SPARSE: begin
                        pop <= ($urandom_range(0, 3) == 0);
                    end
                    DRAIN_LONG_HOLD: begin
                        // Hold pop low for long spells so the queue backs up.
                        if (hold > 0) begin
                            pop <= 1'b0;
                            hold--;
                        end else begin
                            pop <= 1'b1;
                            if ($urandom_range(0, 3) == 0)
                                hold = $urandom_range(5, 30);
                        end
                    end
                    default: begin
                        pop <= 1'b1;
                    end
                endcase
            end
        end
    end

endmodule
